[sv/vas_pkg.sv]
// Shared types and constants for the vector angle pipeline.
package vas_pkg;

    localparam int FIELD_BITS = 16;
    localparam int NW         = 34;   // CORDIC datapath width
    localparam int ZW         = 32;   // angle accumulator width, 2^32 per turn
    localparam int NORM_TOP   = 30;   // operands normalized below 2^30
    localparam int GRP        = 8;    // leading-one search group size

    localparam logic MODE_UNSIGNED = 1'b0;
    localparam logic MODE_SIGNED   = 1'b1;

    localparam logic [ZW-1:0] Z_QUARTER       = 32'h4000_0000;
    localparam logic [ZW-1:0] Z_THREE_QUARTER = 32'hC000_0000;
    localparam logic [15:0]   CENT_TURN       = 16'd36000;
    localparam logic [15:0]   CENT_HALF       = 16'd18000;

    localparam logic [ZW-1:0] ATAN_TAB [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef struct packed {
        logic               req_type;
        logic signed [15:0] a_x;
        logic signed [15:0] a_y;
        logic signed [15:0] a_z;
        logic signed [15:0] b_x;
        logic signed [15:0] b_y;
        logic signed [15:0] b_z;
        logic signed [15:0] n_x;
        logic signed [15:0] n_y;
        logic signed [15:0] n_z;
    } req_t;

    typedef struct packed {
        logic [15:0] angle_centideg;
        logic        zero_vector_error;
    } rsp_t;

    // Control that travels with each item down the pipeline.
    typedef struct packed {
        logic valid;
        logic mode;
        logic err;
        logic dneg;
        logic yzero;
    } side_t;

endpackage

[sv/vas_front.sv]
// Cross product, dot product and the squared magnitude or normal projection.
module vas_front #(
    parameter int CB = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  vas_pkg::req_t                item,
    output vas_pkg::side_t               side_o,
    output logic signed [2*CB+1-((2*CB>32)?(2*CB-32):0):0] x_o,
    output logic signed [2*(2*CB+2-((2*CB>32)?(2*CB-32):0))+1:0] s_o
);
    localparam int S   = (2*CB > 32) ? (2*CB - 32) : 0;
    localparam int CW  = 2*CB + 1 - S;
    localparam int DW  = 2*CB + 2 - S;
    localparam int MW  = CW + 1;
    localparam int SW  = 2*MW + 2;
    localparam int PRW = 2*CB;

    function automatic logic signed [CB-1:0] ext_comp(input logic [vas_pkg::FIELD_BITS-1:0] f);
        logic [63:0] w;
        w = 64'(f);
        return $signed(w[CB-1:0]);
    endfunction

    // stage 1: components
    logic signed [CB-1:0] a_reg [3];
    logic signed [CB-1:0] b_reg [3];
    logic signed [CB-1:0] n_reg [3];
    logic signed [CB-1:0] a_next [3];
    logic signed [CB-1:0] b_next [3];
    logic signed [CB-1:0] n_next [3];
    vas_pkg::side_t side1_reg, side1_next;

    always_comb
    begin
        a_next[0] = ext_comp(item.a_x);
        a_next[1] = ext_comp(item.a_y);
        a_next[2] = ext_comp(item.a_z);
        b_next[0] = ext_comp(item.b_x);
        b_next[1] = ext_comp(item.b_y);
        b_next[2] = ext_comp(item.b_z);
        n_next[0] = ext_comp(item.n_x);
        n_next[1] = ext_comp(item.n_y);
        n_next[2] = ext_comp(item.n_z);
        side1_next       = '0;
        side1_next.valid = accept;
        side1_next.mode  = item.req_type;
        side1_next.err   = (a_next[0] == '0 && a_next[1] == '0 && a_next[2] == '0) ||
                           (b_next[0] == '0 && b_next[1] == '0 && b_next[2] == '0);
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        n_reg <= n_next;
    end

    // stage 2: partial products
    logic signed [PRW-1:0] pc_reg [6];
    logic signed [PRW-1:0] pd_reg [3];
    logic signed [CB-1:0]  n2_reg [3];
    vas_pkg::side_t side2_reg;

    always_ff @(posedge clk)
    begin
        pc_reg[0] <= a_reg[1] * b_reg[2];
        pc_reg[1] <= a_reg[2] * b_reg[1];
        pc_reg[2] <= a_reg[2] * b_reg[0];
        pc_reg[3] <= a_reg[0] * b_reg[2];
        pc_reg[4] <= a_reg[0] * b_reg[1];
        pc_reg[5] <= a_reg[1] * b_reg[0];
        pd_reg[0] <= a_reg[0] * b_reg[0];
        pd_reg[1] <= a_reg[1] * b_reg[1];
        pd_reg[2] <= a_reg[2] * b_reg[2];
        n2_reg    <= n_reg;
    end

    // stage 3: cross and dot, prescaled
    logic signed [CW-1:0] c_reg [3];
    logic signed [CW-1:0] c_next [3];
    logic signed [DW-1:0] d3_reg, d3_next;
    logic signed [CB-1:0] n3_reg [3];
    logic signed [2*CB:0]   cf [3];
    logic signed [2*CB:0]   cs [3];
    logic signed [2*CB+1:0] df, ds;
    vas_pkg::side_t side3_reg, side3_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            cf[i] = (2*CB+1)'(pc_reg[2*i]) - (2*CB+1)'(pc_reg[2*i+1]);
            cs[i] = cf[i] >>> S;
            c_next[i] = $signed(cs[i][CW-1:0]);
        end
        df = (2*CB+2)'(pd_reg[0]) + (2*CB+2)'(pd_reg[1]) + (2*CB+2)'(pd_reg[2]);
        ds = df >>> S;
        d3_next = $signed(ds[DW-1:0]);
        side3_next = side2_reg;
        side3_next.dneg = d3_next < 0;
    end

    always_ff @(posedge clk)
    begin
        c_reg  <= c_next;
        d3_reg <= d3_next;
        n3_reg <= n2_reg;
    end

    // stage 4: squares of |c| or products n*c on a shared set of multipliers
    logic signed [2*MW-1:0] pr_reg [3];
    logic signed [MW-1:0]   mc [3];
    logic signed [MW-1:0]   ma [3];
    logic signed [MW-1:0]   mb [3];
    logic signed [DW-1:0]   d4_reg;
    vas_pkg::side_t side4_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mc[i] = (c_reg[i] < 0) ? -MW'(c_reg[i]) : MW'(c_reg[i]);
            if (side3_reg.mode == vas_pkg::MODE_SIGNED)
            begin
                ma[i] = MW'(n3_reg[i]);
                mb[i] = MW'(c_reg[i]);
            end
            else
            begin
                ma[i] = mc[i];
                mb[i] = mc[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            pr_reg[i] <= ma[i] * mb[i];
        d4_reg <= d3_reg;
    end

    // stage 5: sum
    logic signed [SW-1:0] s5_reg;
    logic signed [DW-1:0] d5_reg;
    vas_pkg::side_t side5_reg;

    always_ff @(posedge clk)
    begin
        s5_reg <= SW'(pr_reg[0]) + SW'(pr_reg[1]) + SW'(pr_reg[2]);
        d5_reg <= d4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side1_reg <= '0;
            side2_reg <= '0;
            side3_reg <= '0;
            side4_reg <= '0;
            side5_reg <= '0;
        end
        else
        begin
            side1_reg <= side1_next;
            side2_reg <= side1_reg;
            side3_reg <= side3_next;
            side4_reg <= side3_reg;
            side5_reg <= side4_reg;
        end
    end

    assign side_o = side5_reg;
    assign x_o    = d5_reg;
    assign s_o    = s5_reg;

endmodule

[sv/vas_isqrt.sv]
// Pipelined digit-by-digit square root, one root bit per stage; in signed mode the sum passes through unrooted.
module vas_isqrt #(
    parameter int CB = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  vas_pkg::side_t       side_i,
    input  logic signed [2*CB+1-((2*CB>32)?(2*CB-32):0):0] x_i,
    input  logic signed [2*(2*CB+2-((2*CB>32)?(2*CB-32):0))+1:0] s_i,
    output vas_pkg::side_t       side_o,
    output logic signed [2*CB+1-((2*CB>32)?(2*CB-32):0):0] x_o,
    output logic signed [2*(2*CB+2-((2*CB>32)?(2*CB-32):0))+1:0] y_o
);
    localparam int S   = (2*CB > 32) ? (2*CB - 32) : 0;
    localparam int CW  = 2*CB + 1 - S;
    localparam int DW  = 2*CB + 2 - S;
    localparam int MW  = CW + 1;
    localparam int SW  = 2*MW + 2;
    localparam int RW  = CW + 1;
    localparam int RMW = CW + 2;

    logic [RW-1:0]        r_reg   [CW];
    logic [RMW-1:0]       rem_reg [CW];
    logic signed [SW-1:0] s_reg   [CW];
    logic signed [DW-1:0] x_reg   [CW];
    vas_pkg::side_t       side_reg [CW];

    for (genvar j = 0; j < CW; j++)
    begin : g_st
        logic [RW-1:0]        r_in;
        logic [RMW-1:0]       rem_in;
        logic signed [SW-1:0] s_in;
        logic signed [DW-1:0] x_in;
        vas_pkg::side_t       side_in;
        logic [RMW+1:0]       remw;
        logic [RMW+1:0]       trial;
        logic [RW-1:0]        r_next;
        logic [RMW-1:0]       rem_next;

        if (j == 0)
        begin : g_first
            assign r_in    = '0;
            assign rem_in  = '0;
            assign s_in    = s_i;
            assign x_in    = x_i;
            assign side_in = side_i;
        end
        else
        begin : g_next
            assign r_in    = r_reg[j-1];
            assign rem_in  = rem_reg[j-1];
            assign s_in    = s_reg[j-1];
            assign x_in    = x_reg[j-1];
            assign side_in = side_reg[j-1];
        end

        always_comb
        begin
            remw  = {rem_in, s_in[2*CW-1-2*j -: 2]};
            trial = (RMW+2)'({r_in, 2'b01});
            if (remw >= trial)
            begin
                rem_next = RMW'(remw - trial);
                r_next   = {r_in[RW-2:0], 1'b1};
            end
            else
            begin
                rem_next = RMW'(remw);
                r_next   = {r_in[RW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            r_reg[j]   <= r_next;
            rem_reg[j] <= rem_next;
            s_reg[j]   <= s_in;
            x_reg[j]   <= x_in;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                side_reg[j] <= '0;
            else
                side_reg[j] <= side_in;
        end
    end

    assign side_o = side_reg[CW-1];
    assign x_o    = x_reg[CW-1];
    assign y_o    = (side_reg[CW-1].mode == vas_pkg::MODE_SIGNED) ?
                    s_reg[CW-1] : $signed(SW'(r_reg[CW-1]));

endmodule

[sv/vas_norm.sv]
// Joint power-of-two scaling of the CORDIC operands and quadrant pre-rotation.
module vas_norm #(
    parameter int CB = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  vas_pkg::side_t       side_i,
    input  logic signed [2*CB+1-((2*CB>32)?(2*CB-32):0):0] x_i,
    input  logic signed [2*(2*CB+2-((2*CB>32)?(2*CB-32):0))+1:0] y_i,
    output vas_pkg::side_t       side_o,
    output logic signed [vas_pkg::NW-1:0] x_o,
    output logic signed [vas_pkg::NW-1:0] y_o,
    output logic [vas_pkg::ZW-1:0]        z_o
);
    localparam int S   = (2*CB > 32) ? (2*CB - 32) : 0;
    localparam int CW  = 2*CB + 1 - S;
    localparam int MW  = CW + 1;
    localparam int SW  = 2*MW + 2;
    localparam int NG  = (SW + vas_pkg::GRP - 1) / vas_pkg::GRP;
    localparam int PW  = NG * vas_pkg::GRP;
    localparam int LW  = $clog2(SW + 1);
    localparam int NW  = vas_pkg::NW;
    localparam int ZW  = vas_pkg::ZW;

    // stage N1: widen, flag zero Y, magnitude union
    logic signed [SW-1:0] x1_reg, y1_reg, x1_next;
    logic [PW-1:0]        or1_reg;
    logic [SW-1:0]        mx, my;
    vas_pkg::side_t       side1_reg, side1_next;

    always_comb
    begin
        x1_next = SW'(x_i);
        mx = (x1_next < 0) ? SW'(-x1_next) : SW'(x1_next);
        my = (y_i < 0) ? SW'(-y_i) : SW'(y_i);
        side1_next = side_i;
        side1_next.yzero = (y_i == '0);
    end

    always_ff @(posedge clk)
    begin
        x1_reg  <= x1_next;
        y1_reg  <= y_i;
        or1_reg <= PW'(mx | my);
    end

    // stage N2: leading one within each group
    logic [NG-1:0][3:0]   gl_reg, gl_next;
    logic signed [SW-1:0] x2_reg, y2_reg;
    vas_pkg::side_t       side2_reg;

    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            gl_next[g] = '0;
            for (int b = 0; b < vas_pkg::GRP; b++)
                if (or1_reg[g*vas_pkg::GRP + b])
                    gl_next[g] = 4'(b + 1);
        end
    end

    always_ff @(posedge clk)
    begin
        gl_reg <= gl_next;
        x2_reg <= x1_reg;
        y2_reg <= y1_reg;
    end

    // stage N3: bit length and shift amounts
    logic [LW-1:0]        len;
    logic [LW-1:0]        shr_reg, shl_reg, shr_next, shl_next;
    logic signed [SW-1:0] x3_reg, y3_reg;
    vas_pkg::side_t       side3_reg;

    always_comb
    begin
        len = '0;
        for (int g = 0; g < NG; g++)
            if (gl_reg[g] != '0)
                len = LW'(g * vas_pkg::GRP) + LW'(gl_reg[g]);
        shr_next = (len > LW'(vas_pkg::NORM_TOP)) ? LW'(len - LW'(vas_pkg::NORM_TOP)) : '0;
        shl_next = (len < LW'(vas_pkg::NORM_TOP)) ? LW'(LW'(vas_pkg::NORM_TOP) - len) : '0;
    end

    always_ff @(posedge clk)
    begin
        shr_reg <= shr_next;
        shl_reg <= shl_next;
        x3_reg  <= x2_reg;
        y3_reg  <= y2_reg;
    end

    // stage N4: barrel shift
    logic signed [SW-1:0] xsh, ysh;
    logic signed [NW-1:0] x4_reg, y4_reg;
    vas_pkg::side_t       side4_reg;

    always_comb
    begin
        xsh = (x3_reg >>> shr_reg) <<< shl_reg;
        ysh = (y3_reg >>> shr_reg) <<< shl_reg;
    end

    always_ff @(posedge clk)
    begin
        x4_reg <= $signed(xsh[NW-1:0]);
        y4_reg <= $signed(ysh[NW-1:0]);
    end

    // stage N5: move a left-half vector into the right half plane
    logic signed [NW-1:0] x5_reg, y5_reg, x5_next, y5_next;
    logic [ZW-1:0]        z5_reg, z5_next;
    vas_pkg::side_t       side5_reg;

    always_comb
    begin
        x5_next = x4_reg;
        y5_next = y4_reg;
        z5_next = '0;
        if (x4_reg < 0)
        begin
            if (y4_reg >= 0)
            begin
                x5_next = y4_reg;
                y5_next = -x4_reg;
                z5_next = vas_pkg::Z_QUARTER;
            end
            else
            begin
                x5_next = -y4_reg;
                y5_next = x4_reg;
                z5_next = vas_pkg::Z_THREE_QUARTER;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x5_reg <= x5_next;
        y5_reg <= y5_next;
        z5_reg <= z5_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side1_reg <= '0;
            side2_reg <= '0;
            side3_reg <= '0;
            side4_reg <= '0;
            side5_reg <= '0;
        end
        else
        begin
            side1_reg <= side1_next;
            side2_reg <= side1_reg;
            side3_reg <= side2_reg;
            side4_reg <= side3_reg;
            side5_reg <= side4_reg;
        end
    end

    assign side_o = side5_reg;
    assign x_o    = x5_reg;
    assign y_o    = y5_reg;
    assign z_o    = z5_reg;

endmodule

[sv/vas_cordic.sv]
// Vectoring CORDIC, one micro-rotation per pipeline stage.
module vas_cordic #(
    parameter int STEPS = 20
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  vas_pkg::side_t                side_i,
    input  logic signed [vas_pkg::NW-1:0] x_i,
    input  logic signed [vas_pkg::NW-1:0] y_i,
    input  logic [vas_pkg::ZW-1:0]        z_i,
    output vas_pkg::side_t                side_o,
    output logic [vas_pkg::ZW-1:0]        z_o
);
    localparam int NW = vas_pkg::NW;
    localparam int ZW = vas_pkg::ZW;

    logic signed [NW-1:0] x_reg [STEPS];
    logic signed [NW-1:0] y_reg [STEPS];
    logic [ZW-1:0]        z_reg [STEPS];
    vas_pkg::side_t       side_reg [STEPS];

    for (genvar i = 0; i < STEPS; i++)
    begin : g_st
        logic signed [NW-1:0] x_in, y_in, dx, dy;
        logic [ZW-1:0]        z_in;
        vas_pkg::side_t       side_in;

        if (i == 0)
        begin : g_first
            assign x_in    = x_i;
            assign y_in    = y_i;
            assign z_in    = z_i;
            assign side_in = side_i;
        end
        else
        begin : g_next
            assign x_in    = x_reg[i-1];
            assign y_in    = y_reg[i-1];
            assign z_in    = z_reg[i-1];
            assign side_in = side_reg[i-1];
        end

        assign dx = y_in >>> i;
        assign dy = x_in >>> i;

        always_ff @(posedge clk)
        begin
            if (y_in >= 0)
            begin
                x_reg[i] <= x_in + dx;
                y_reg[i] <= y_in - dy;
                z_reg[i] <= z_in + vas_pkg::ATAN_TAB[i];
            end
            else
            begin
                x_reg[i] <= x_in - dx;
                y_reg[i] <= y_in + dy;
                z_reg[i] <= z_in - vas_pkg::ATAN_TAB[i];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                side_reg[i] <= '0;
            else
                side_reg[i] <= side_in;
        end
    end

    assign side_o = side_reg[STEPS-1];
    assign z_o    = z_reg[STEPS-1];

endmodule

[sv/vector_angle_signed.sv]
// Angle between two 3D vectors, unsigned or signed about a normal.
//
// Usage: drive item and raise start for one cycle per vector pair. busy is
// always low, so a transfer happens on every cycle that start is high and a
// new pair may follow in the very next cycle: one pair per clock, sustained.
// Each pair yields exactly one result on the result port, marked by done for
// a single cycle; results leave in the order the pairs came in.
// From transfer to done a pair passes five stages of cross/dot products,
// CW square-root stages (one root bit each), five normalization stages,
// one stage per CORDIC micro-rotation and two output stages, where
// CW = 2*COMPONENT_BITS + 1 - max(0, 2*COMPONENT_BITS - 32).
// The receiver cannot stall; it must take the result in the cycle done is
// high. Reset clears all valid bits, so no done appears until new pairs
// are transferred. A zero vector a or b gives angle 0 with
// zero_vector_error set.
module vector_angle_signed #(
    parameter int COMPONENT_BITS = 16,
    parameter int CORDIC_STEPS   = 20
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  vas_pkg::req_t  item,
    output logic           done,
    output vas_pkg::rsp_t  result
);
    localparam int CB = COMPONENT_BITS;
    localparam int S  = (2*CB > 32) ? (2*CB - 32) : 0;
    localparam int CW = 2*CB + 1 - S;
    localparam int DW = 2*CB + 2 - S;
    localparam int MW = CW + 1;
    localparam int SW = 2*MW + 2;
    localparam int NW = vas_pkg::NW;
    localparam int ZW = vas_pkg::ZW;
    localparam int PRW = ZW + 16;

    vas_pkg::side_t       side_f, side_q, side_n, side_c;
    logic signed [DW-1:0] x_f, x_q;
    logic signed [SW-1:0] s_f, y_q;
    logic signed [NW-1:0] x_n, y_n;
    logic [ZW-1:0]        z_n, z_c;

    assign busy = 1'b0;

    vas_front #(.CB(CB)) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (start && !busy),
        .item   (item),
        .side_o (side_f),
        .x_o    (x_f),
        .s_o    (s_f)
    );

    vas_isqrt #(.CB(CB)) u_isqrt (
        .clk    (clk),
        .rst_n  (rst_n),
        .side_i (side_f),
        .x_i    (x_f),
        .s_i    (s_f),
        .side_o (side_q),
        .x_o    (x_q),
        .y_o    (y_q)
    );

    vas_norm #(.CB(CB)) u_norm (
        .clk    (clk),
        .rst_n  (rst_n),
        .side_i (side_q),
        .x_i    (x_q),
        .y_i    (y_q),
        .side_o (side_n),
        .x_o    (x_n),
        .y_o    (y_n),
        .z_o    (z_n)
    );

    vas_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .side_i (side_n),
        .x_i    (x_n),
        .y_i    (y_n),
        .z_i    (z_n),
        .side_o (side_c),
        .z_o    (z_c)
    );

    // output stage 1: scale the turn fraction to hundredths of a degree
    logic [PRW-1:0] prod_reg;
    logic           zhi_reg;
    vas_pkg::side_t side_o1_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PRW'(z_c) * PRW'(vas_pkg::CENT_TURN);
        zhi_reg  <= (z_c >= vas_pkg::Z_THREE_QUARTER);
    end

    // output stage 2: round, wrap, clamp and apply special cases
    logic [PRW-1:0] rnd;
    logic [15:0]    cent;
    vas_pkg::rsp_t  rsp_reg, rsp_next;
    logic           done_reg;

    always_comb
    begin
        rnd  = prod_reg + (PRW'(1) << (ZW - 1));
        cent = rnd[PRW-1:ZW];
        if (cent >= vas_pkg::CENT_TURN)
            cent = '0;
        if (side_o1_reg.mode == vas_pkg::MODE_UNSIGNED)
        begin
            if (zhi_reg)
                cent = '0;
            else if (cent > vas_pkg::CENT_HALF)
                cent = vas_pkg::CENT_HALF;
        end
        if (side_o1_reg.yzero)
            cent = side_o1_reg.dneg ? vas_pkg::CENT_HALF : '0;
        rsp_next.angle_centideg    = side_o1_reg.err ? '0 : cent;
        rsp_next.zero_vector_error = side_o1_reg.err;
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_o1_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            side_o1_reg <= side_c;
            done_reg    <= side_o1_reg.valid;
        end
    end

    assign done   = done_reg;
    assign result = rsp_reg;

endmodule
